// ----- rtl/csb_pkg.sv -----
// shared action and status codes for the counting semaphore bank
package csb_pkg;

    typedef enum logic [1:0] {
        ACT_CREATE  = 2'd0,
        ACT_DESTROY = 2'd1,
        ACT_WAIT    = 2'd2,
        ACT_SIGNAL  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_BAD_INDEX   = 3'd1,
        STS_NOT_IN_USE  = 3'd2,
        STS_FULL        = 3'd3,
        STS_NEGATIVE    = 3'd4,
        STS_WOULD_BLOCK = 3'd5,
        STS_SATURATED   = 3'd6
    } status_t;

    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int INIT_W   = 16;
    localparam int OUTCNT_W = 16;

endpackage

// ----- rtl/counting_semaphore_bank_core.sv -----
// counting semaphore bank: slot memory with read-modify-write sequencer
//
//  channel   | handshake            | signals
//  ----------+----------------------+------------------------------------------
//  request   | start & !busy        | action, sem_index, initial_count
//  result    | done (one cycle)     | status, allocated_index, count_after
//
// destroy, wait and signal do one memory read, then the write-back in S_EXEC.
// create reads slots in S_SCAN from the free hint up, passing the in-use slots, until one is free;
// a scan that runs past the last slot answers bank full.
// rejects found at accept (bad index, negative count, bank full) answer straight from idle.
// after reset a clearing pass holds busy high while it writes every slot.
// results cannot be stalled; done pulses once per accepted transaction.
module counting_semaphore_bank_core #(
    parameter int NUM_SEMAPHORES = 64,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          action,
    input  logic [csb_pkg::INDEX_W-1:0]         sem_index,
    input  logic signed [csb_pkg::INIT_W-1:0]   initial_count,
    output logic                                done,
    output logic [csb_pkg::STATUS_W-1:0]        status,
    output logic [csb_pkg::INDEX_W-1:0]         allocated_index,
    output logic [csb_pkg::OUTCNT_W-1:0]        count_after
);

    localparam int AW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int HW = $clog2(NUM_SEMAPHORES + 1);
    localparam int CW = COUNT_WIDTH;
    localparam int MW = CW + 1;
    localparam int XW = (CW > 16) ? CW : 16;
    localparam int WIDE_IDX = 11;
    localparam logic [WIDE_IDX-1:0] NUM_WIDE = WIDE_IDX'(NUM_SEMAPHORES);
    localparam logic [HW-1:0] NUM_H = HW'(NUM_SEMAPHORES);
    localparam logic [AW-1:0] LAST_A = AW'(NUM_SEMAPHORES - 1);
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_SCAN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [HW-1:0] hint_reg, hint_next;
    logic [AW-1:0] scan_reg, scan_next;
    logic [1:0] act_reg, act_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] init_reg, init_next;

    logic done_reg;
    logic [csb_pkg::STATUS_W-1:0] status_reg;
    logic [csb_pkg::INDEX_W-1:0] alloc_reg;
    logic [csb_pkg::OUTCNT_W-1:0] count_reg;

    // slot memory: {in_use, count}
    logic [MW-1:0] slot_mem [NUM_SEMAPHORES];
    logic [MW-1:0] mem_rdata_reg;
    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata;

    logic res_valid;
    logic [csb_pkg::STATUS_W-1:0] res_status;
    logic [AW-1:0] res_idx;
    logic [CW-1:0] res_cnt;
    logic [XW-1:0] res_cnt_x;
    logic [WIDE_IDX-1:0] res_idx_x;

    logic [WIDE_IDX-1:0] sem_idx_x;
    logic [AW-1:0] in_addr;
    logic in_bad;
    logic [XW-1:0] init_x;
    logic [XW-1:0] cmax_x;
    logic [CW-1:0] init_sat;
    logic rd_use;
    logic [CW-1:0] rd_cnt;
    logic [HW-1:0] scan_inc;

    assign sem_idx_x = WIDE_IDX'(sem_index);
    assign in_addr   = sem_idx_x[AW-1:0];
    assign in_bad    = sem_idx_x >= NUM_WIDE;
    assign init_x    = XW'(initial_count[csb_pkg::INIT_W-2:0]);
    assign cmax_x    = XW'(CNT_MAX);
    assign init_sat  = (init_x > cmax_x) ? CNT_MAX : init_x[CW-1:0];
    assign rd_use    = mem_rdata_reg[CW];
    assign rd_cnt    = mem_rdata_reg[CW-1:0];
    assign scan_inc  = HW'(scan_reg) + HW'(1);
    assign res_cnt_x = XW'(res_cnt);
    assign res_idx_x = WIDE_IDX'(res_idx);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= slot_mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        hint_next  = hint_reg;
        scan_next  = scan_reg;
        act_next   = act_reg;
        idx_next   = idx_reg;
        init_next  = init_reg;
        mem_we     = 1'b0;
        mem_waddr  = scan_reg;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = in_addr;
        res_valid  = 1'b0;
        res_status = csb_pkg::STS_OK;
        res_idx    = '0;
        res_cnt    = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_A)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next  = action;
                    idx_next  = in_addr;
                    init_next = init_sat;
                    if (action == csb_pkg::ACT_CREATE)
                    begin
                        if (initial_count[csb_pkg::INIT_W-1])
                        begin
                            res_valid  = 1'b1;
                            res_status = csb_pkg::STS_NEGATIVE;
                        end
                        else if (hint_reg == NUM_H)
                        begin
                            res_valid  = 1'b1;
                            res_status = csb_pkg::STS_FULL;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = hint_reg[AW-1:0];
                            scan_next  = hint_reg[AW-1:0];
                            state_next = S_SCAN;
                        end
                    end
                    else if (in_bad)
                    begin
                        res_valid  = 1'b1;
                        res_status = csb_pkg::STS_BAD_INDEX;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = S_EXEC;
                    end
                end
            end
            S_SCAN:
            begin
                if (!rd_use)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = scan_reg;
                    mem_wdata  = {1'b1, init_reg};
                    res_valid  = 1'b1;
                    res_idx    = scan_reg;
                    res_cnt    = init_reg;
                    hint_next  = scan_inc;
                    state_next = S_IDLE;
                end
                else if (scan_inc == NUM_H)
                begin
                    res_valid  = 1'b1;
                    res_status = csb_pkg::STS_FULL;
                    hint_next  = NUM_H;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = scan_inc[AW-1:0];
                    scan_next = scan_inc[AW-1:0];
                end
            end
            S_EXEC:
            begin
                res_valid  = 1'b1;
                state_next = S_IDLE;
                mem_waddr  = idx_reg;
                if (!rd_use)
                begin
                    res_status = csb_pkg::STS_NOT_IN_USE;
                    res_cnt    = rd_cnt;
                end
                else
                begin
                    unique case (act_reg)
                        csb_pkg::ACT_DESTROY:
                        begin
                            mem_we = 1'b1;
                            // freed slot below the hint becomes the lowest free one
                            if (HW'(idx_reg) < hint_reg)
                            begin
                                hint_next = HW'(idx_reg);
                            end
                        end
                        csb_pkg::ACT_WAIT:
                        begin
                            if (rd_cnt == '0)
                            begin
                                res_status = csb_pkg::STS_WOULD_BLOCK;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {1'b1, rd_cnt - CW'(1)};
                                res_cnt   = rd_cnt - CW'(1);
                            end
                        end
                        csb_pkg::ACT_SIGNAL:
                        begin
                            if (rd_cnt == CNT_MAX)
                            begin
                                res_status = csb_pkg::STS_SATURATED;
                                res_cnt    = CNT_MAX;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {1'b1, rd_cnt + CW'(1)};
                                res_cnt   = rd_cnt + CW'(1);
                            end
                        end
                        default:
                        begin
                            res_cnt = rd_cnt;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            hint_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hint_reg  <= hint_next;
            done_reg  <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        act_reg  <= act_next;
        idx_reg  <= idx_next;
        init_reg <= init_next;
        if (res_valid)
        begin
            status_reg <= res_status;
            alloc_reg  <= res_idx_x[csb_pkg::INDEX_W-1:0];
            count_reg  <= res_cnt_x[csb_pkg::OUTCNT_W-1:0];
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign allocated_index = alloc_reg;
    assign count_after     = count_reg;

endmodule

// ----- rtl/csb_checker.sv -----
// port-level checks for the counting semaphore bank, bound to the top level
module csb_assertions (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [1:0]                        action,
    input logic [csb_pkg::INDEX_W-1:0]       sem_index,
    input logic signed [csb_pkg::INIT_W-1:0] initial_count,
    input logic                              done,
    input logic [csb_pkg::STATUS_W-1:0]      status,
    input logic [csb_pkg::INDEX_W-1:0]       allocated_index,
    input logic [csb_pkg::OUTCNT_W-1:0]      count_after
);

    // a result only shows while the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted transaction either answers at once or keeps the bank busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted transaction vanished");

    a_alloc_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != csb_pkg::STS_OK) |-> (allocated_index == '0))
        else $error("allocated index on a failed request");

    a_reject_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == csb_pkg::STS_BAD_INDEX || status == csb_pkg::STS_FULL ||
                  status == csb_pkg::STS_NEGATIVE || status == csb_pkg::STS_WOULD_BLOCK))
        |-> (count_after == '0))
        else $error("nonzero count on a rejected request");

    // a create that is rejected for a negative count answers in the next cycle
    a_negative_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == csb_pkg::ACT_CREATE && initial_count[15])
        |=> (done && status == csb_pkg::STS_NEGATIVE))
        else $error("negative create not rejected");

endmodule

bind counting_semaphore_bank_core csb_assertions u_csb_checker (.*);

// ----- tb/sv/csb_checker.sv -----
`timescale 1ns / 1ps
// checker: predicts every semaphore bank reply and compares it with the block's output
module csb_checker #(
    parameter int NUM_SEMAPHORES = 64,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [1:0]                          action,
    input  logic [csb_pkg::INDEX_W-1:0]         sem_index,
    input  logic [csb_pkg::INIT_W-1:0]          initial_count,
    input  logic                                done,
    input  logic [csb_pkg::STATUS_W-1:0]        status,
    input  logic [csb_pkg::INDEX_W-1:0]         allocated_index,
    input  logic [csb_pkg::OUTCNT_W-1:0]        count_after,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  checked_count,
    output logic [6:0]                          status_seen
);

    typedef struct packed {
        csb_pkg::status_t                st;
        logic [csb_pkg::INDEX_W-1:0]     slot;
        logic [csb_pkg::OUTCNT_W-1:0]    cnt;
    } sem_reply_t;

    localparam longint unsigned CNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

    longint unsigned sem_count [NUM_SEMAPHORES];
    bit              sem_live  [NUM_SEMAPHORES];
    sem_reply_t      reply_q [$];
    sem_reply_t      want;

    // applies one request to the shadow bank and returns the reply it must give
    function automatic sem_reply_t apply_request(csb_pkg::action_t act,
                                                 logic [csb_pkg::INDEX_W-1:0] idx,
                                                 logic [csb_pkg::INIT_W-1:0] init);
        sem_reply_t      r;
        int              free_slot;
        longint unsigned c;
        longint unsigned cur;
        r.st = csb_pkg::STS_OK;
        r.slot = '0;
        r.cnt = '0;
        free_slot = -1;
        if (act == csb_pkg::ACT_CREATE)
        begin
            if (init[csb_pkg::INIT_W-1])
            begin
                r.st = csb_pkg::STS_NEGATIVE;
            end
            else
            begin
                // lowest free slot wins
                for (int i = NUM_SEMAPHORES - 1; i >= 0; i--)
                    if (!sem_live[i])
                        free_slot = i;
                if (free_slot < 0)
                begin
                    r.st = csb_pkg::STS_FULL;
                end
                else
                begin
                    c = (64'(init) > CNT_MAX) ? CNT_MAX : 64'(init);
                    sem_live[free_slot] = 1'b1;
                    sem_count[free_slot] = c;
                    r.slot = free_slot[csb_pkg::INDEX_W-1:0];
                    r.cnt = c[csb_pkg::OUTCNT_W-1:0];
                end
            end
        end
        else if (int'(idx) >= NUM_SEMAPHORES)
        begin
            r.st = csb_pkg::STS_BAD_INDEX;
        end
        else if (!sem_live[idx])
        begin
            cur = sem_count[idx];
            r.st = csb_pkg::STS_NOT_IN_USE;
            r.cnt = cur[csb_pkg::OUTCNT_W-1:0];
        end
        else
        begin
            case (act)
                csb_pkg::ACT_DESTROY:
                begin
                    sem_live[idx] = 1'b0;
                    sem_count[idx] = '0;
                end
                csb_pkg::ACT_WAIT:
                begin
                    if (sem_count[idx] == 64'd0)
                    begin
                        r.st = csb_pkg::STS_WOULD_BLOCK;
                    end
                    else
                    begin
                        sem_count[idx] = sem_count[idx] - 64'd1;
                        cur = sem_count[idx];
                        r.cnt = cur[csb_pkg::OUTCNT_W-1:0];
                    end
                end
                default:
                begin
                    if (sem_count[idx] >= CNT_MAX)
                    begin
                        sem_count[idx] = CNT_MAX;
                        r.st = csb_pkg::STS_SATURATED;
                        r.cnt = CNT_MAX[csb_pkg::OUTCNT_W-1:0];
                    end
                    else
                    begin
                        sem_count[idx] = sem_count[idx] + 64'd1;
                        cur = sem_count[idx];
                        r.cnt = cur[csb_pkg::OUTCNT_W-1:0];
                    end
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SEMAPHORES; i++)
            begin
                sem_count[i] = '0;
                sem_live[i] = 1'b0;
            end
            reply_q.delete();
            fail_count = 0;
            pending_count = 0;
            checked_count = 0;
            status_seen = '0;
        end
        else
        begin
            // the reply finishing now belongs to an older transaction, so check first
            if (done)
            begin
                checked_count++;
                if (status < 3'd7)
                    status_seen[status] = 1'b1;
                if (reply_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected reply: status %0d slot %0d count %0d",
                             $time, status, allocated_index, count_after);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (status !== want.st)
                    begin
                        fail_count++;
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.st, status);
                    end
                    if (allocated_index !== want.slot)
                    begin
                        fail_count++;
                        $display("%0t allocated_index mismatch: expected %0d actual %0d",
                                 $time, want.slot, allocated_index);
                    end
                    if (count_after !== want.cnt)
                    begin
                        fail_count++;
                        $display("%0t count_after mismatch: expected %0d actual %0d",
                                 $time, want.cnt, count_after);
                    end
                end
            end
            if (start && !busy)
                reply_q.push_back(apply_request(csb_pkg::action_t'(action), sem_index,
                                                initial_count));
            pending_count = reply_q.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top: request stimulus for the counting semaphore bank and the final verdict
module tb_top;

    localparam int IW = csb_pkg::INDEX_W;
    localparam int NW = csb_pkg::INIT_W;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic [1:0]                         action;
    logic [IW-1:0]                      sem_index;
    logic [NW-1:0]                      initial_count;
    logic                               done;
    logic [csb_pkg::STATUS_W-1:0]       status;
    logic [IW-1:0]                      allocated_index;
    logic [csb_pkg::OUTCNT_W-1:0]       count_after;

    int                     fail_count;
    int                     pending_count;
    int                     checked_count;
    logic [6:0]             status_seen;
    int                     sent_count;
    int                     idle_pct;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    counting_semaphore_bank_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .sem_index       (sem_index),
        .initial_count   (initial_count),
        .done            (done),
        .status          (status),
        .allocated_index (allocated_index),
        .count_after     (count_after)
    );

    csb_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .sem_index       (sem_index),
        .initial_count   (initial_count),
        .done            (done),
        .status          (status),
        .allocated_index (allocated_index),
        .count_after     (count_after),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .checked_count   (checked_count),
        .status_seen     (status_seen)
    );

    // idle cycles carry random noise on the request fields with start low
    task automatic send_request(input csb_pkg::action_t act, input logic [IW-1:0] idx,
                                input logic [NW-1:0] init);
        while (int'($urandom_range(0, 99)) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            action <= 2'($urandom);
            sem_index <= IW'($urandom);
            initial_count <= NW'($urandom);
        end
        @(negedge clk);
        start <= 1'b1;
        action <= act;
        sem_index <= idx;
        initial_count <= init;
        do
            @(posedge clk);
        while (busy);
        sent_count++;
    endtask

    task automatic random_request(input int create_w, input int destroy_w);
        int                 roll;
        csb_pkg::action_t   act;
        logic [IW-1:0]      idx;
        logic [NW-1:0]      init;
        roll = int'($urandom_range(0, 99));
        if (roll < create_w)
            act = csb_pkg::ACT_CREATE;
        else if (roll < create_w + destroy_w)
            act = csb_pkg::ACT_DESTROY;
        else if (roll < create_w + destroy_w + (100 - create_w - destroy_w) / 2)
            act = csb_pkg::ACT_WAIT;
        else
            act = csb_pkg::ACT_SIGNAL;
        // low slots are the ones create hands out first
        if ($urandom_range(0, 9) < 7)
            idx = IW'($urandom_range(0, 15));
        else
            idx = IW'($urandom);
        roll = int'($urandom_range(0, 99));
        if (roll < 60)
            init = NW'($urandom_range(0, 3));
        else if (roll < 85)
            init = NW'($urandom);
        else
            init = NW'($urandom_range(0, 32767));
        send_request(act, idx, init);
    endtask

    initial
    begin
        int idle_plan [4];
        idle_plan = '{0, 51, 0, 24};
        rst_n = 1'b0;
        start = 1'b0;
        action = csb_pkg::ACT_CREATE;
        sem_index = '0;
        initial_count = '0;
        sent_count = 0;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // one slot at the largest initial count, a few steps up and down
        send_request(csb_pkg::ACT_CREATE, 6'd0, 16'h7fff);
        send_request(csb_pkg::ACT_SIGNAL, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_SIGNAL, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_WAIT, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_SIGNAL, 6'd63, 16'hffff);
        send_request(csb_pkg::ACT_SIGNAL, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_DESTROY, 6'd0, 16'h0000);

        // directed corners on an empty bank
        send_request(csb_pkg::ACT_DESTROY, 6'd5, 16'h0000);
        send_request(csb_pkg::ACT_WAIT, 6'd63, 16'h0000);
        send_request(csb_pkg::ACT_SIGNAL, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_CREATE, 6'd0, 16'h8000);
        send_request(csb_pkg::ACT_CREATE, 6'd63, 16'hffff);
        send_request(csb_pkg::ACT_CREATE, 6'd42, 16'h0000);
        send_request(csb_pkg::ACT_WAIT, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_SIGNAL, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_WAIT, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_WAIT, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_CREATE, 6'd0, 16'h7fff);
        send_request(csb_pkg::ACT_WAIT, 6'd1, 16'h0000);
        send_request(csb_pkg::ACT_DESTROY, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_WAIT, 6'd0, 16'h0000);
        send_request(csb_pkg::ACT_CREATE, 6'd0, 16'h0005);
        send_request(csb_pkg::ACT_DESTROY, 6'd1, 16'h0000);
        send_request(csb_pkg::ACT_DESTROY, 6'd0, 16'h0000);

        // random traffic: fill-heavy and drain-heavy phases alternate
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = idle_plan[ph];
            repeat (400)
            begin
                if (ph % 2 == 0)
                    random_request(40, 10);
                else
                    random_request(15, 35);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        wait (pending_count == 0);
        repeat (80) @(posedge clk);

        $display("run covered %0d requests over four idle phases and %0d checked replies",
                 sent_count, checked_count);
        $display("status codes observed (bit per code): %b", status_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d replies outstanding", pending_count);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/csb_pkg.sv
rtl/counting_semaphore_bank_core.sv
rtl/csb_checker.sv
tb/sv/csb_checker.sv
tb/sv/tb_top.sv
